// File: sv/chi_pkg.sv
// shared widths, codes and the divider status type for the chained hash insert block
package chi_pkg;

  // width of a record key
  localparam int unsigned KEY_W = 31;
  // width of the bucket count register
  localparam int unsigned CNT_W = 7;
  // width of the bus data word
  localparam int unsigned DATA_W = 32;

  // result status codes
  localparam logic STATUS_STORED = 1'b0;
  localparam logic STATUS_FULL   = 1'b1;

  // register byte addresses
  localparam logic [2:0] ADDR_BUCKET_COUNT = 3'd0;

  // status of the remainder unit
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rem;
  } div_stat_t;

endpackage

// File: sv/chained_hash_insert.sv
// hash table insert with separate chaining: record store, bucket tails, sequencer
//
//  channel   | handshake              | fields
//  ----------+------------------------+----------------------------------
//  insert    | start_i / busy_o       | key_i, payload_i
//  result    | done_o (one cycle)     | status_o, slot_o, bucket_o
//  config    | psel/penable/pwrite    | paddr, pwdata, prdata (bucket_count)
//
// An insert passes through the states DIV (the bit-serial remainder unit hashes
// the key), LOOK, WRITE, LINK (only when it links after a chain tail) and RESP;
// when the store is full it goes from DIV straight to RESP.
// A new word is accepted the cycle after the result strobe.
// After reset a clearing pass marks every bucket empty with busy_o high;
// configuration writes are taken during it.
// The result is shown for one cycle only; the receiver cannot stall it.
module chained_hash_insert
  import chi_pkg::*;
#(
  parameter int unsigned BUCKETS = 64,
  parameter int unsigned RECORDS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // insert channel
  input  logic              start_i,
  output logic              busy_o,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [31:0]       payload_i,
  // result channel
  output logic              done_o,
  output logic              status_o,
  output logic [7:0]        slot_o,
  output logic [5:0]        bucket_o,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned SW = $clog2(RECORDS);
  localparam int unsigned LW = $clog2(RECORDS + 1);
  localparam logic [LW-1:0] LINK_NONE = LW'(RECORDS);

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(10);

  // sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_LOOK  = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;
  localparam logic [2:0] ST_LINK  = 3'd5;
  localparam logic [2:0] ST_RESP  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [BW-1:0]     clr_q, clr_d;
  logic [LW-1:0]     fill_q, fill_d;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  eff_count;
  logic              full_q, full_d;
  logic [KEY_W-1:0]  key_q;
  logic [31:0]       payload_q;
  logic [SW-1:0]     slot_q;
  logic [CNT_W-1:0]  bkt_q, bkt_d;
  logic [31:0]       bkt_ext;
  logic [31:0]       slot_ext;
  logic [BW-1:0]     bkt_idx;
  logic              accept;
  logic              cfg_wr;
  div_stat_t         div_stat;

  // bucket tail table and record store
  logic [LW-1:0]     tail_mem [BUCKETS];
  logic [LW-1:0]     tail_rd_q;
  logic [KEY_W-1:0]  key_mem [RECORDS];
  logic [31:0]       payload_mem [RECORDS];
  logic [LW-1:0]     next_mem [RECORDS];

  logic              tail_we;
  logic [BW-1:0]     tail_wa;
  logic [LW-1:0]     tail_wd;
  logic              next_we;
  logic [SW-1:0]     next_wa;
  logic [LW-1:0]     next_wd;

  assign accept = start_i && (state_q == ST_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == ADDR_BUCKET_COUNT[2]);

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (cfg_wr) begin
      count_q <= pwdata[CNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_BUCKET_COUNT[2]) ? DATA_W'(count_q) : '0;

  // zero count acts as one, counts above the table saturate
  always_comb begin
    if (count_q == '0) begin
      eff_count = CNT_W'(1);
    end else if (32'(count_q) > BUCKETS) begin
      eff_count = CNT_W'(BUCKETS);
    end else begin
      eff_count = count_q;
    end
  end

  chi_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (key_i),
    .divisor_i  (eff_count),
    .stat_o     (div_stat)
  );

  // remainder stays below the bucket count, so it fits the table index
  assign bkt_ext = 32'(bkt_q);
  assign bkt_idx = bkt_ext[BW-1:0];

  // sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    fill_d  = fill_q;
    full_d  = full_q;
    bkt_d   = bkt_q;
    tail_we = 1'b0;
    tail_wa = bkt_idx;
    tail_wd = LW'(slot_q);
    next_we = 1'b0;
    next_wa = slot_q;
    next_wd = LINK_NONE;
    case (state_q)
      ST_CLEAR: begin
        tail_we = 1'b1;
        tail_wa = clr_q;
        tail_wd = LINK_NONE;
        clr_d   = clr_q + BW'(1);
        if (clr_q == BW'(BUCKETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          full_d  = (fill_q == LINK_NONE);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          bkt_d   = div_stat.rem;
          state_d = full_q ? ST_RESP : ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        // new record gets an empty link and becomes the bucket tail
        next_we = 1'b1;
        tail_we = 1'b1;
        fill_d  = fill_q + LW'(1);
        state_d = (tail_rd_q == LINK_NONE) ? ST_RESP : ST_LINK;
      end
      ST_LINK: begin
        // link the old tail to the new record
        next_we = 1'b1;
        next_wa = tail_rd_q[SW-1:0];
        next_wd = LW'(slot_q);
        state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      fill_q  <= '0;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      fill_q  <= fill_d;
      full_q  <= full_d;
    end
  end

  // captured insert word
  always_ff @(posedge clk_i) begin
    bkt_q <= bkt_d;
    if (accept) begin
      key_q     <= key_i;
      payload_q <= payload_i;
      slot_q    <= fill_q[SW-1:0];
    end
  end

  // bucket tail table, registered read
  always_ff @(posedge clk_i) begin
    if (tail_we) begin
      tail_mem[tail_wa] <= tail_wd;
    end
    tail_rd_q <= tail_mem[bkt_idx];
  end

  // record store
  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE) begin
      key_mem[slot_q]     <= key_q;
      payload_mem[slot_q] <= payload_q;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
  end

  // result word
  assign slot_ext = 32'(slot_q);
  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = (state_q == ST_RESP);
  assign status_o = full_q ? STATUS_FULL : STATUS_STORED;
  assign slot_o   = full_q ? 8'd0 : slot_ext[7:0];
  assign bucket_o = bkt_q[5:0];

endmodule

// File: sv/chi_mod_unit.sv
// bit-serial remainder unit: key modulo bucket count, one quotient bit per cycle
module chi_mod_unit
  import chi_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KEY_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output div_stat_t        stat_o
);

  localparam int unsigned STEP_W = $clog2(KEY_W);

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [KEY_W-1:0]  dvd_q, dvd_d;
  logic [CNT_W-1:0]  div_q, div_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;

  // one restoring step: shift in the next key bit, subtract if it fits
  assign trial = {rem_q, dvd_q[KEY_W-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (run_q) begin
      // trial stays below twice the divisor, so either result fits
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[CNT_W-1:0];
      end else begin
        rem_d = trial[CNT_W-1:0];
      end
      dvd_d  = {dvd_q[KEY_W-2:0], 1'b0};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(KEY_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.rem  = rem_q;

endmodule

// File: dv/tb_chained_hash_insert.sv
// testbench for the chained hash insert block: directed corners, bucket count changes, random inserts
`timescale 1ns / 1ps

module tb_chained_hash_insert
  import chi_pkg::*;
();

  localparam int unsigned BUCKETS = 64;
  localparam int unsigned RECORDS = 256;
  localparam logic [8:0] LINK_NONE = 9'(RECORDS);
  localparam int unsigned INSERT_LATENCY = 40;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic       status;
    logic [7:0] slot;
    logic [5:0] bucket;
  } insert_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [KEY_W-1:0]  key_i = '0;
  logic [31:0]       payload_i = '0;
  logic              done_o;
  logic              status_o;
  logic [7:0]        slot_o;
  logic [5:0]        bucket_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // shadow of the table state
  logic [CNT_W-1:0] cfg_bucket_count;
  logic [8:0]       bucket_first [BUCKETS];
  logic [8:0]       slot_link [RECORDS];
  bit               slot_used [RECORDS];

  insert_result_t pending_inserts [$];
  insert_result_t head_result;
  int unsigned    error_count = 0;
  int unsigned    cycle_count = 0;
  int unsigned    sender_idle_pct = 0;

  chained_hash_insert #(
    .BUCKETS(BUCKETS),
    .RECORDS(RECORDS)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .key_i    (key_i),
    .payload_i(payload_i),
    .done_o   (done_o),
    .status_o (status_o),
    .slot_o   (slot_o),
    .bucket_o (bucket_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk_i = ~clk_i;

  // run length guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_chained_hash_insert: errors");
      $finish;
    end
  end

  // predicted insert: lowest free slot, head or append after the chain tail
  function automatic insert_result_t predict_insert(input logic [KEY_W-1:0] key);
    int unsigned n;
    int unsigned bkt;
    int unsigned free_slot;
    int unsigned cur;
    int unsigned nxt;
    int unsigned steps;
    insert_result_t r;
    n = cfg_bucket_count;
    if (n == 0) n = 1;
    if (n > BUCKETS) n = BUCKETS;
    bkt = key % n;
    free_slot = RECORDS;
    for (int i = RECORDS - 1; i >= 0; i--) begin
      if (!slot_used[i]) free_slot = i;
    end
    r.bucket = bkt[5:0];
    if (free_slot == RECORDS) begin
      r.status = STATUS_FULL;
      r.slot = '0;
      return r;
    end
    slot_used[free_slot] = 1'b1;
    slot_link[free_slot] = LINK_NONE;
    if (bucket_first[bkt] >= LINK_NONE) begin
      bucket_first[bkt] = free_slot[8:0];
    end else begin
      cur = bucket_first[bkt];
      steps = 0;
      while (steps < RECORDS) begin
        nxt = slot_link[cur];
        if (nxt >= LINK_NONE || nxt == free_slot) break;
        cur = nxt;
        steps++;
      end
      slot_link[cur] = free_slot[8:0];
    end
    r.status = STATUS_STORED;
    r.slot = free_slot[7:0];
    return r;
  endfunction

  // result checker: each strobe against the oldest pending insert
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_inserts.size() == 0) begin
        $error("unexpected result: status %0d slot %0d bucket %0d",
               status_o, slot_o, bucket_o);
        error_count++;
      end else begin
        head_result = pending_inserts.pop_front();
        if (status_o !== head_result.status) begin
          $error("status: expected %0d, got %0d", head_result.status, status_o);
          error_count++;
        end
        if (slot_o !== head_result.slot) begin
          $error("slot: expected %0d, got %0d", head_result.slot, slot_o);
          error_count++;
        end
        if (bucket_o !== head_result.bucket) begin
          $error("bucket: expected %0d, got %0d", head_result.bucket, bucket_o);
          error_count++;
        end
      end
    end
  end

  // send one word; idle cycle by cycle with junk on the key and payload lines first
  task automatic insert_word(input logic [KEY_W-1:0] key, input logic [31:0] payload);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      key_i <= KEY_W'($urandom());
      payload_i <= $urandom();
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    key_i <= key;
    payload_i <= payload;
    do @(posedge clk_i); while (busy_o);
    pending_inserts.push_back(predict_insert(key));
  endtask

  // drop start and wait until every pending result is back
  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_inserts.size() != 0) @(posedge clk_i);
  endtask

  // write bucket_count, then read it back
  task automatic set_bucket_count(input logic [CNT_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_BUCKET_COUNT;
    pwdata <= DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cfg_bucket_count = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pwdata <= $urandom();
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== DATA_W'(value)) begin
      $error("bucket_count readback: expected %0d, got %0d", value, prdata);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(3))
      0: return KEY_W'($urandom());
      1: return KEY_W'($urandom_range(0, 300));
      2: return KEY_W'(32'h7fff_ffff - $urandom_range(0, 300));
      default: return KEY_W'($urandom_range(0, 4095) * 64 + $urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_bucket_count();
    case ($urandom_range(7))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd2;
      3: return 7'd64;
      4: return 7'd127;
      5: return 7'd65;
      6: return CNT_W'($urandom_range(1, 64));
      default: return CNT_W'($urandom_range(0, 127));
    endcase
  endfunction

  // field extremes and chains under the reset bucket count
  task automatic test_directed_extremes();
    sender_idle_pct = 0;
    insert_word(31'd0, 32'h0000_0000);
    insert_word(31'h7fff_ffff, 32'hffff_ffff);
    insert_word(31'd10, 32'ha5a5_a5a5);
    insert_word(31'd20, 32'h5a5a_5a5a);
    insert_word(31'd30, 32'h0000_0001);
    insert_word(31'd7, 32'h8000_0000);
    insert_word(31'd9, 32'h1234_5678);
    insert_word(31'h5555_5555, 32'h5555_5555);
    insert_word(31'h2aaa_aaaa, 32'haaaa_aaaa);
    wait_idle();
  endtask

  // zero count, saturation above the bucket limit, count changes over live chains
  task automatic test_bucket_count_corners();
    sender_idle_pct = 21;
    set_bucket_count(7'd0);
    insert_word(31'd12345, $urandom());
    insert_word(31'h7fff_ffff, $urandom());
    wait_idle();
    set_bucket_count(7'd127);
    insert_word(31'd63, $urandom());
    insert_word(31'd64, $urandom());
    insert_word(31'd127, $urandom());
    insert_word(31'h7fff_ffff, $urandom());
    wait_idle();
    set_bucket_count(7'd65);
    insert_word(31'd100, $urandom());
    insert_word(31'd164, $urandom());
    wait_idle();
    set_bucket_count(7'd64);
    insert_word(31'h7fff_ffc0, $urandom());
    insert_word(31'd0, $urandom());
    wait_idle();
    set_bucket_count(7'd1);
    insert_word(31'd5, $urandom());
    wait_idle();
    set_bucket_count(7'd2);
    insert_word(31'h7fff_ffff, $urandom());
    insert_word(31'd2, $urandom());
    wait_idle();
  endtask

  // random inserts in four parts, each under a fresh bucket count
  task automatic test_random_inserts(input int unsigned idle_pct, input int unsigned count);
    sender_idle_pct = idle_pct;
    for (int part = 0; part < 4; part++) begin
      wait_idle();
      set_bucket_count(pick_bucket_count());
      for (int unsigned i = 0; i < count / 4; i++) begin
        insert_word(pick_key(), $urandom());
      end
    end
  endtask

  initial begin
    cfg_bucket_count = 7'd10;
    for (int i = 0; i < BUCKETS; i++) bucket_first[i] = LINK_NONE;
    for (int i = 0; i < RECORDS; i++) begin
      slot_used[i] = 1'b0;
      slot_link[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_extremes();
    test_bucket_count_corners();
    test_random_inserts(21, 316);
    test_random_inserts(45, 316);
    test_random_inserts(0, 320);

    wait_idle();
    repeat (2 * INSERT_LATENCY) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_chained_hash_insert: clean");
    end else begin
      $display("tb_chained_hash_insert: errors");
    end
    $finish;
  end

endmodule
